@@ sv/iirlp_pkg.sv @@
`timescale 1ns / 1ps

package iirlp_pkg;

   localparam int SAMPLE_W = 16;
   localparam int SHIFT_W  = 4;
   localparam int AXES     = 3;

   localparam logic [SHIFT_W-1:0] GYRO_SHIFT_RESET = 4'd2;
   localparam logic [SHIFT_W-1:0] MAG_SHIFT_RESET  = 4'd3;

   localparam logic KIND_FILTER = 1'b0;
   localparam logic KIND_RESET  = 1'b1;

   localparam logic CHAN_GYRO = 1'b0;
   localparam logic CHAN_MAG  = 1'b1;

   localparam logic CSR_GYRO_SHIFT = 1'b0;
   localparam logic CSR_MAG_SHIFT  = 1'b1;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_REJECT = 2'd1,
      STATUS_RESET  = 2'd2
   } status_type;

   typedef struct packed {
      logic                       kind;
      logic                       channel;
      logic signed [SAMPLE_W-1:0] sample_x;
      logic signed [SAMPLE_W-1:0] sample_y;
      logic signed [SAMPLE_W-1:0] sample_z;
   } req_type;

   typedef struct packed {
      status_type                 status;
      logic signed [SAMPLE_W-1:0] filtered_x;
      logic signed [SAMPLE_W-1:0] filtered_y;
      logic signed [SAMPLE_W-1:0] filtered_z;
   } rsp_type;

   typedef struct packed {
      logic               clr;
      logic               load;
      logic               upd;
      logic               channel;
      logic [SHIFT_W-1:0] shift;
   } lane_ctl_type;

endpackage

@@ sv/iirlp_lane.sv @@
`timescale 1ns / 1ps

module iirlp_lane #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  iirlp_pkg::lane_ctl_type              ctl,
   input  logic signed [iirlp_pkg::SAMPLE_W-1:0] sample,
   output logic signed [iirlp_pkg::SAMPLE_W-1:0] filtered
);
   import iirlp_pkg::*;

   localparam int ACC_W = SAMPLE_W + FRACTION_BITS;

   logic signed [ACC_W-1:0] acc_ff [2];
   logic signed [ACC_W-1:0] acc_in [2];
   logic signed [ACC_W-1:0] acc_cur;
   logic signed [ACC_W-1:0] target;
   logic signed [ACC_W:0]   diff;
   logic signed [ACC_W:0]   diff_sh;
   logic signed [ACC_W:0]   sum;
   logic signed [ACC_W-1:0] acc_next;

   assign acc_cur  = acc_ff[ctl.channel];
   assign target   = ACC_W'(sample) <<< FRACTION_BITS;
   assign diff     = (ACC_W+1)'(target) - (ACC_W+1)'(acc_cur);
   assign diff_sh  = diff >>> ctl.shift;
   assign sum      = (ACC_W+1)'(acc_cur) + diff_sh;
   assign acc_next = ACC_W'(sum);

   always_comb begin
      acc_in[0] = acc_ff[0];
      acc_in[1] = acc_ff[1];
      if (ctl.clr) begin
         acc_in[ctl.channel] = '0;
      end else if (ctl.load) begin
         acc_in[ctl.channel] = target;
      end else if (ctl.upd) begin
         acc_in[ctl.channel] = acc_next;
      end
   end

   assign filtered = ctl.load ? sample : acc_next[FRACTION_BITS +: SAMPLE_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff[0] <= '0;
         acc_ff[1] <= '0;
      end else begin
         acc_ff[0] <= acc_in[0];
         acc_ff[1] <= acc_in[1];
      end
   end

endmodule

@@ sv/iirlp_merge.sv @@
`timescale 1ns / 1ps

module iirlp_merge (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  iirlp_pkg::status_type                in_status,
   input  logic signed [iirlp_pkg::SAMPLE_W-1:0] lane_val [iirlp_pkg::AXES],
   input  logic                                 rsp_stall,
   output logic                                 rsp_valid,
   output iirlp_pkg::rsp_type                   rsp_data,
   output logic                                 full
);
   import iirlp_pkg::*;

   rsp_type merged;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   logic    out_take;
   logic    pass;

   // combine lane results, zero unless filtered
   always_comb begin
      pass              = (in_status == STATUS_OK);
      merged.status     = in_status;
      merged.filtered_x = pass ? lane_val[0] : '0;
      merged.filtered_y = pass ? lane_val[1] : '0;
      merged.filtered_z = pass ? lane_val[2] : '0;
   end

   assign out_take = out_valid_ff && !rsp_stall;

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (in_valid) begin
         if (!out_valid_ff || out_take) begin
            out_in       = merged;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = merged;
            skid_valid_in = 1'b1;
         end
      end else if (out_take) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign full      = skid_valid_ff;

endmodule

@@ sv/dual_three_axis_iir_lowpass_top.sv @@
`timescale 1ns / 1ps
// channel   direction  handshake            payload
// req       in         req_valid/req_stall  req_data (kind, channel, xyz sample)
// rsp       out        rsp_valid/rsp_stall  rsp_data (status, filtered xyz)
// csr       in         csr_we               csr_index, csr_wdata
//
// one request per cycle unless req_stall; response registered in output or skid entry
// the three axis lanes update their accumulators in the accept cycle
// a two-entry output buffer (register plus skid) holds responses under rsp_stall
// req_stall rises only when both entries are full
// synchronous reset clears accumulators and primed flags and reloads the default shifts

module dual_three_axis_iir_lowpass_top #(
   parameter int FRACTION_BITS = 8
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  iirlp_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output iirlp_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [iirlp_pkg::SHIFT_W-1:0]        csr_wdata
);
   import iirlp_pkg::*;

   logic [SHIFT_W-1:0]         gyro_shift_ff, gyro_shift_in;
   logic [SHIFT_W-1:0]         mag_shift_ff, mag_shift_in;
   logic [1:0]                 primed_ff, primed_in;
   logic                       req_accept;
   logic                       frame_bad;
   logic                       primed_cur;
   status_type                 status;
   lane_ctl_type               ctl;
   logic signed [SAMPLE_W-1:0] samples  [AXES];
   logic signed [SAMPLE_W-1:0] lane_val [AXES];
   logic                       buf_full;

   assign req_stall  = buf_full;
   assign req_accept = req_valid && !req_stall;

   assign samples[0] = req_data.sample_x;
   assign samples[1] = req_data.sample_y;
   assign samples[2] = req_data.sample_z;

   assign frame_bad =
      (req_data.sample_x == '0 && req_data.sample_y == '0 && req_data.sample_z == '0) ||
      (req_data.sample_x == '1 && req_data.sample_y == '1 && req_data.sample_z == '1);

   assign primed_cur = primed_ff[req_data.channel];

   always_comb begin
      if (req_data.kind == KIND_RESET) begin
         status = STATUS_RESET;
      end else if (frame_bad) begin
         status = STATUS_REJECT;
      end else begin
         status = STATUS_OK;
      end
   end

   always_comb begin
      ctl.channel = req_data.channel;
      ctl.shift   = (req_data.channel == CHAN_MAG) ? mag_shift_ff : gyro_shift_ff;
      ctl.clr     = req_accept && (status == STATUS_RESET);
      ctl.load    = req_accept && (status == STATUS_OK) && !primed_cur;
      ctl.upd     = req_accept && (status == STATUS_OK) && primed_cur;
   end

   always_comb begin
      primed_in = primed_ff;
      if (ctl.clr) begin
         primed_in[req_data.channel] = 1'b0;
      end else if (ctl.load) begin
         primed_in[req_data.channel] = 1'b1;
      end
   end

   always_comb begin
      gyro_shift_in = gyro_shift_ff;
      mag_shift_in  = mag_shift_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_GYRO_SHIFT: gyro_shift_in = csr_wdata;
            CSR_MAG_SHIFT:  mag_shift_in  = csr_wdata;
            default:        gyro_shift_in = gyro_shift_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gyro_shift_ff <= GYRO_SHIFT_RESET;
         mag_shift_ff  <= MAG_SHIFT_RESET;
         primed_ff     <= '0;
      end else begin
         gyro_shift_ff <= gyro_shift_in;
         mag_shift_ff  <= mag_shift_in;
         primed_ff     <= primed_in;
      end
   end

   for (genvar i = 0; i < AXES; i++) begin : g_lane
      iirlp_lane #(
         .FRACTION_BITS(FRACTION_BITS)
      ) u_lane (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sample   (samples[i]),
         .filtered (lane_val[i])
      );
   end

   iirlp_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_accept),
      .in_status (status),
      .lane_val  (lane_val),
      .rsp_stall (rsp_stall),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .full      (buf_full)
   );

   // skid entry only fills behind a held output
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      buf_full |-> rsp_valid)
      else $error("skid entry valid without output entry");

   // channel reset drops the primed flag
   a_reset_unprimes: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.kind == KIND_RESET)
      |=> !primed_ff[$past(req_data.channel)])
      else $error("channel still primed after reset request");

   // every accepted request leaves a response pending
   a_accept_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid)
      else $error("accepted request produced no response");

   // a drained buffer with no new request goes empty
   a_drain_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_accept && !buf_full) |=> !rsp_valid)
      else $error("response repeated after it was taken");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import iirlp_pkg::*;

   localparam int FRACTION_BITS = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int SEGMENT_REQUESTS = 285;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic csr_index = 1'b0;
   logic [SHIFT_W-1:0] csr_wdata = '0;

   req_type pending_requests[$];
   rsp_type expected_responses[$];

   int axis_acc [6];
   bit primed [2];
   logic [SHIFT_W-1:0] gyro_shift_m = GYRO_SHIFT_RESET;
   logic [SHIFT_W-1:0] mag_shift_m = MAG_SHIFT_RESET;

   int send_idle_pct = 6;
   int recv_stall_pct = 63;
   int failures = 0;
   int cycle_count = 0;

   dual_three_axis_iir_lowpass_top #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // expected response for one accepted request, updates the filter state
   task automatic iir_predict(input req_type r);
      rsp_type exp_rsp;
      int samp [3];
      int filt [3];
      int base;
      int shift;
      exp_rsp = '0;
      samp[0] = $signed(r.sample_x);
      samp[1] = $signed(r.sample_y);
      samp[2] = $signed(r.sample_z);
      filt = '{0, 0, 0};
      base = (r.channel == CHAN_MAG) ? 3 : 0;
      shift = (r.channel == CHAN_MAG) ? int'(mag_shift_m) : int'(gyro_shift_m);
      if (r.kind == KIND_RESET) begin
         for (int i = 0; i < AXES; i++) axis_acc[base + i] = 0;
         primed[r.channel] = 1'b0;
         exp_rsp.status = STATUS_RESET;
      end else if ((samp[0] == 0 && samp[1] == 0 && samp[2] == 0) ||
                   (samp[0] == -1 && samp[1] == -1 && samp[2] == -1)) begin
         exp_rsp.status = STATUS_REJECT;
      end else if (!primed[r.channel]) begin
         for (int i = 0; i < AXES; i++) begin
            axis_acc[base + i] = samp[i] * (1 << FRACTION_BITS);
            filt[i] = samp[i];
         end
         primed[r.channel] = 1'b1;
         exp_rsp.status = STATUS_OK;
      end else begin
         for (int i = 0; i < AXES; i++) begin
            axis_acc[base + i] += (samp[i] * (1 << FRACTION_BITS) - axis_acc[base + i])
                                  >>> shift;
            filt[i] = axis_acc[base + i] >>> FRACTION_BITS;
         end
         exp_rsp.status = STATUS_OK;
      end
      exp_rsp.filtered_x = 16'(filt[0]);
      exp_rsp.filtered_y = 16'(filt[1]);
      exp_rsp.filtered_z = 16'(filt[2]);
      expected_responses.push_back(exp_rsp);
   endtask

   function automatic req_type make_request(input logic kind, input logic channel,
                                            input int x, input int y, input int z);
      req_type r;
      r.kind = kind;
      r.channel = channel;
      r.sample_x = 16'(x);
      r.sample_y = 16'(y);
      r.sample_z = 16'(z);
      return r;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_axis(input int mode);
      case (mode)
         0: return 16'($urandom);
         1: return 16'(int'($urandom_range(0, 200)) - 100);
         default: begin
            case ($urandom_range(3))
               0: return 16'h8000;
               1: return 16'h7fff;
               2: return 16'h0000;
               default: return 16'hffff;
            endcase
         end
      endcase
   endfunction

   function automatic req_type random_request();
      req_type r;
      int pick;
      int mode;
      pick = $urandom_range(99);
      mode = $urandom_range(9);
      r.kind = KIND_FILTER;
      r.channel = 1'($urandom_range(1));
      if (pick < 4) begin
         r.kind = KIND_RESET;
         mode = 0;
      end else if (mode < 5) begin
         mode = 0;
      end else if (mode < 8) begin
         mode = 1;
      end else begin
         mode = 2;
      end
      r.sample_x = random_axis(mode);
      r.sample_y = random_axis(mode);
      r.sample_z = random_axis(mode);
      if (pick >= 4 && pick < 9) begin
         // invalid frame
         if ($urandom_range(1)) r = make_request(KIND_FILTER, r.channel, 0, 0, 0);
         else r = make_request(KIND_FILTER, r.channel, -1, -1, -1);
      end
      return r;
   endfunction

   task automatic write_shift(input logic idx, input logic [SHIFT_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == CSR_GYRO_SHIFT) gyro_shift_m = val;
      else mag_shift_m = val;
   endtask

   task automatic wait_idle();
      @(posedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_responses.size() != 0)
         @(posedge clock);
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) iir_predict(req_data);
         if (!req_valid || !req_stall) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_requests.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_responses.size() == 0) begin
               $error("unexpected response status %0d", rsp_data.status);
               failures++;
            end else begin
               exp_rsp = expected_responses.pop_front();
               if (rsp_data.status !== exp_rsp.status) begin
                  $error("status expected %0d actual %0d", exp_rsp.status, rsp_data.status);
                  failures++;
               end
               if (rsp_data.filtered_x !== exp_rsp.filtered_x) begin
                  $error("filtered_x expected %0d actual %0d",
                         exp_rsp.filtered_x, rsp_data.filtered_x);
                  failures++;
               end
               if (rsp_data.filtered_y !== exp_rsp.filtered_y) begin
                  $error("filtered_y expected %0d actual %0d",
                         exp_rsp.filtered_y, rsp_data.filtered_y);
                  failures++;
               end
               if (rsp_data.filtered_z !== exp_rsp.filtered_z) begin
                  $error("filtered_z expected %0d actual %0d",
                         exp_rsp.filtered_z, rsp_data.filtered_z);
                  failures++;
               end
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      logic [SHIFT_W-1:0] g_cfg;
      logic [SHIFT_W-1:0] m_cfg;
      axis_acc = '{0, 0, 0, 0, 0, 0};
      primed = '{1'b0, 1'b0};
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed requests at reset shift values
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, -1, -1, -1));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 32767, -32768, 0));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, -32768, 32767, -1));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 0, 0, 1));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, -1, -1, 0));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, -1, -1, -1));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, -32768, -32768, -32768));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, 32767, 32767, 32767));
      pending_requests.push_back(make_request(KIND_RESET, CHAN_GYRO, -1, 32767, -32768));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, 32767, 32767, 32767));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 100, -100, 5));
      pending_requests.push_back(make_request(KIND_RESET, CHAN_MAG, 0, 0, 0));
      pending_requests.push_back(make_request(KIND_RESET, CHAN_MAG, -1, -1, -1));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, 1, 2, 3));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_GYRO, 32767, 32767, 32767));
      pending_requests.push_back(make_request(KIND_FILTER, CHAN_MAG, -32768, 0, 32767));
      wait_idle();

      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle_pct = 6;
               recv_stall_pct = 63;
            end
            1: begin
               send_idle_pct = 63;
               recv_stall_pct = 6;
            end
            default: begin
               send_idle_pct = 0;
               recv_stall_pct = 0;
            end
         endcase
         case (seg)
            0: begin
               g_cfg = 4'd0;
               m_cfg = 4'd15;
            end
            1: begin
               g_cfg = 4'd15;
               m_cfg = 4'd0;
            end
            4: begin
               g_cfg = 4'd1;
               m_cfg = 4'd1;
            end
            default: begin
               g_cfg = 4'($urandom_range(15));
               m_cfg = 4'($urandom_range(15));
            end
         endcase
         write_shift(CSR_GYRO_SHIFT, g_cfg);
         write_shift(CSR_MAG_SHIFT, m_cfg);
         for (int n = 0; n < SEGMENT_REQUESTS; n++)
            pending_requests.push_back(random_request());
         wait_idle();
      end

      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
sv/iirlp_pkg.sv
sv/iirlp_lane.sv
sv/iirlp_merge.sv
sv/dual_three_axis_iir_lowpass_top.sv
bench/tb_top.sv
